FILE: src/iccp_pkg.sv
// ----------------------------------------------------------------------------
// iccp_pkg
// Shared types and constants for the caret color code text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package iccp_pkg;

  localparam int COL_W       = 11;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  localparam logic [6:0] CARET_CODE   = 7'h5E;
  localparam logic [6:0] CODE_RESET_L = 7'h72;
  localparam logic [6:0] CODE_RESET_U = 7'h52;
  localparam logic [6:0] CODE_BOLD_L  = 7'h62;
  localparam logic [6:0] CODE_BOLD_U  = 7'h42;
  localparam logic [6:0] CODE_SHAD_L  = 7'h73;
  localparam logic [6:0] CODE_SHAD_U  = 7'h53;
  localparam logic [6:0] CODE_ITAL_L  = 7'h69;
  localparam logic [6:0] CODE_ITAL_U  = 7'h49;
  localparam logic [6:0] CODE_DIGIT_0 = 7'h30;
  localparam logic [6:0] CODE_DIGIT_9 = 7'h39;

  localparam logic [7:0] LEVEL_FULL = 8'd255;
  localparam logic [7:0] LEVEL_DARK = 8'd185;
  localparam logic [7:0] LEVEL_NONE = 8'd0;
  localparam logic [7:0] BOLD_MASK  = 8'h80;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam rgb_t WHITE = '{red: LEVEL_FULL, green: LEVEL_FULL, blue: LEVEL_FULL};

  // one accepted byte that draws: one or two glyphs sharing the same style
  typedef struct packed {
    logic [7:0]       glyph_a;
    logic [7:0]       glyph_b;
    logic [COL_W-1:0] col_a;
    logic [COL_W-1:0] col_b;
    logic             two;
    rgb_t             color;
    logic             italic;
    logic             shadow;
    logic [11:0]      base_x;
    logic [11:0]      base_y;
    logic [8:0]       alpha;
  } draw_rec_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic rgb_t digit_color(input logic [3:0] digit);
    rgb_t c;
    case (digit)
      4'd1:    c = '{red: LEVEL_FULL, green: LEVEL_NONE, blue: LEVEL_NONE};
      4'd2:    c = '{red: LEVEL_NONE, green: LEVEL_FULL, blue: LEVEL_NONE};
      4'd3:    c = '{red: LEVEL_FULL, green: LEVEL_FULL, blue: LEVEL_NONE};
      4'd4:    c = '{red: LEVEL_NONE, green: LEVEL_NONE, blue: LEVEL_FULL};
      4'd5:    c = '{red: LEVEL_NONE, green: LEVEL_FULL, blue: LEVEL_FULL};
      4'd6:    c = '{red: LEVEL_FULL, green: LEVEL_NONE, blue: LEVEL_FULL};
      4'd7:    c = WHITE;
      4'd8:    c = '{red: LEVEL_NONE, green: LEVEL_NONE, blue: LEVEL_NONE};
      4'd9:    c = '{red: LEVEL_DARK, green: LEVEL_NONE, blue: LEVEL_NONE};
      4'd0:    c = '{red: LEVEL_DARK, green: LEVEL_DARK, blue: LEVEL_DARK};
      default: c = WHITE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: src/iccp_front.sv
// ----------------------------------------------------------------------------
// iccp_front
// Accepts text bytes, decodes caret escapes, tracks style and column, and
// pushes one draw record per drawing byte into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module iccp_front import iccp_pkg::*; #(
  parameter int MAX_COLUMNS = 2047
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  char_in_i,
  input  wire logic        end_of_string_i,
  input  wire logic [11:0] base_x_i,
  input  wire logic [11:0] base_y_i,
  input  wire logic [8:0]  alpha_in_i,
  input  wire queue_stat_t q_stat_i,
  output logic             q_push_o,
  output draw_rec_t        q_rec_o
);

  localparam logic [COL_W-1:0] ColMax = COL_W'(MAX_COLUMNS);

  logic             default_bold_q;
  logic             esc_q, esc_d;
  logic [7:0]       pending_q, pending_d;
  rgb_t             color_q, color_d;
  logic             bold_q, bold_d;
  logic             shadow_q, shadow_d;
  logic             italic_q, italic_d;
  logic [COL_W-1:0] col_q, col_d;

  logic             accept;
  logic [6:0]       code;
  logic             is_caret, is_reset, is_bold, is_shad, is_ital, is_digit, is_style;
  logic             draw_one, draw_two;
  logic [COL_W-1:0] col_a, col_b;
  logic [7:0]       bold_mask;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  assign code     = char_in_i[6:0];
  assign is_caret = (code == CARET_CODE);
  assign is_reset = code inside {CODE_RESET_L, CODE_RESET_U};
  assign is_bold  = code inside {CODE_BOLD_L, CODE_BOLD_U};
  assign is_shad  = code inside {CODE_SHAD_L, CODE_SHAD_U};
  assign is_ital  = code inside {CODE_ITAL_L, CODE_ITAL_U};
  assign is_digit = code inside {[CODE_DIGIT_0:CODE_DIGIT_9]};
  assign is_style = is_reset || is_bold || is_shad || is_ital || is_digit;

  assign draw_two = esc_q && !is_caret && !is_style;
  assign draw_one = esc_q ? is_caret : !(is_caret && !end_of_string_i);

  assign col_a = (col_q < ColMax) ? col_q + 1'b1 : col_q;
  assign col_b = (col_a < ColMax) ? col_a + 1'b1 : col_a;

  assign bold_mask = bold_q ? BOLD_MASK : '0;

  always_comb begin
    q_rec_o.glyph_a = (draw_two ? pending_q : char_in_i) ^ bold_mask;
    q_rec_o.glyph_b = char_in_i ^ bold_mask;
    q_rec_o.col_a   = col_a;
    q_rec_o.col_b   = col_b;
    q_rec_o.two     = draw_two;
    q_rec_o.color   = color_q;
    q_rec_o.italic  = italic_q;
    q_rec_o.shadow  = shadow_q;
    q_rec_o.base_x  = base_x_i;
    q_rec_o.base_y  = base_y_i;
    q_rec_o.alpha   = alpha_in_i;
  end

  assign q_push_o = accept && (draw_one || draw_two);

  always_comb begin
    esc_d     = esc_q;
    pending_d = pending_q;
    color_d   = color_q;
    bold_d    = bold_q;
    shadow_d  = shadow_q;
    italic_d  = italic_q;
    col_d     = col_q;
    if (accept) begin
      if (esc_q) begin
        esc_d = 1'b0;
        if (is_reset) begin
          color_d  = WHITE;
          shadow_d = 1'b0;
          italic_d = 1'b0;
          bold_d   = default_bold_q;
        end else if (is_bold) begin
          bold_d = !bold_q;
        end else if (is_shad) begin
          shadow_d = !shadow_q;
        end else if (is_ital) begin
          italic_d = !italic_q;
        end else if (is_digit) begin
          color_d = digit_color(code[3:0]);
        end
      end else if (is_caret && !end_of_string_i) begin
        esc_d     = 1'b1;
        pending_d = char_in_i;
      end
      if (draw_two) begin
        col_d = col_b;
      end else if (draw_one) begin
        col_d = col_a;
      end
      if (end_of_string_i) begin
        esc_d     = 1'b0;
        pending_d = '0;
        col_d     = '0;
        color_d   = WHITE;
        shadow_d  = 1'b0;
        italic_d  = 1'b0;
        bold_d    = default_bold_q;
      end
    end
    if (cfg_we_i) begin
      bold_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_bold_q <= 1'b0;
      esc_q          <= 1'b0;
      pending_q      <= '0;
      color_q        <= WHITE;
      bold_q         <= 1'b0;
      shadow_q       <= 1'b0;
      italic_q       <= 1'b0;
      col_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        default_bold_q <= cfg_wdata_i;
      end
      esc_q     <= esc_d;
      pending_q <= pending_d;
      color_q   <= color_d;
      bold_q    <= bold_d;
      shadow_q  <= shadow_d;
      italic_q  <= italic_d;
      col_q     <= col_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/iccp_queue.sv
// ----------------------------------------------------------------------------
// iccp_queue
// Short queue of draw records between the decoder and the draw sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module iccp_queue import iccp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire queue_ctrl_t ctrl_i,
  input  wire draw_rec_t   rec_i,
  output draw_rec_t   rec_o,
  output queue_stat_t stat_o
);

  draw_rec_t            slots_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CW-1:0]  count_q;
  logic                 do_push, do_pop;

  assign stat_o.full  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = ctrl_i.push && !stat_o.full;
  assign do_pop       = ctrl_i.pop && !stat_o.empty;
  assign rec_o        = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/iccp_back.sv
// ----------------------------------------------------------------------------
// iccp_back
// Expands each draw record into main draws, with shadow draws when shadowed,
// and holds them in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module iccp_back import iccp_pkg::*; #(
  parameter int FONT_PIXELS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire draw_rec_t   rec_i,
  input  wire queue_stat_t q_stat_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      pos_x_o,
  output logic [12:0]      pos_y_o,
  output logic [7:0]       glyph_o,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic [8:0]       alpha_out_o,
  output logic             italic_o,
  output logic             is_shadow_o,
  output logic             last_of_item_o
);

  localparam int SumW = 18;
  localparam logic [SumW-1:0] Font       = SumW'(FONT_PIXELS);
  localparam logic [SumW-1:0] ShadowOffs = SumW'(FONT_PIXELS / 4);

  logic             sel_b_q, sel_b_d;
  logic             main_q, main_d;
  logic             out_valid_q;
  logic             emit, load;
  logic             cur_shadow, cur_last;
  logic [COL_W-1:0] cur_col;
  logic [SumW-1:0]  x_sum;
  logic [15:0]      x_sat;

  assign emit       = !q_stat_i.empty;
  assign load       = emit && (!out_valid_q || !out_stall_i);
  assign cur_shadow = rec_i.shadow && !main_q;
  assign cur_last   = !cur_shadow && (sel_b_q || !rec_i.two);
  assign cur_col    = sel_b_q ? rec_i.col_b : rec_i.col_a;
  assign q_pop_o    = load && cur_last;

  assign x_sum = SumW'(rec_i.base_x) + SumW'(cur_col) * Font
               + (cur_shadow ? ShadowOffs : '0);
  assign x_sat = (x_sum[SumW-1:16] != '0) ? 16'hFFFF : x_sum[15:0];

  always_comb begin
    sel_b_d = sel_b_q;
    main_d  = main_q;
    if (load) begin
      if (cur_shadow) begin
        main_d = 1'b1;
      end else begin
        main_d  = 1'b0;
        sel_b_d = !cur_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_b_q     <= 1'b0;
      main_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sel_b_q <= sel_b_d;
      main_q  <= main_d;
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pos_x_o        <= x_sat;
      pos_y_o        <= {1'b0, rec_i.base_y} + {12'd0, cur_shadow};
      glyph_o        <= sel_b_q ? rec_i.glyph_b : rec_i.glyph_a;
      red_o          <= cur_shadow ? LEVEL_NONE : rec_i.color.red;
      green_o        <= cur_shadow ? LEVEL_NONE : rec_i.color.green;
      blue_o         <= cur_shadow ? LEVEL_NONE : rec_i.color.blue;
      alpha_out_o    <= rec_i.alpha;
      italic_o       <= rec_i.italic;
      is_shadow_o    <= cur_shadow;
      last_of_item_o <= cur_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: src/inline_color_code_text_parser_top.sv
// ----------------------------------------------------------------------------
// inline_color_code_text_parser_top
// Caret color code text parser: text bytes in, glyph draw commands out.
// ----------------------------------------------------------------------------
// Each accepted byte is decoded in the cycle it is taken and, if it draws,
// lands in a four-entry queue; the draw sequencer then emits one draw per
// cycle, unless stalled, through its output register. A plain byte makes one
// draw, a shadowed byte two (shadow then main), a caret with an unknown code
// two or four. Style codes and held carets draw nothing. Input stalls only
// while the queue is full. default_bold may be written only between strings.
`default_nettype none

module inline_color_code_text_parser_top import iccp_pkg::*; #(
  parameter int FONT_PIXELS = 8,
  parameter int MAX_COLUMNS = 2047
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  char_in_i,
  input  wire logic        end_of_string_i,
  input  wire logic [11:0] base_x_i,
  input  wire logic [11:0] base_y_i,
  input  wire logic [8:0]  alpha_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      pos_x_o,
  output logic [12:0]      pos_y_o,
  output logic [7:0]       glyph_o,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic [8:0]       alpha_out_o,
  output logic             italic_o,
  output logic             is_shadow_o,
  output logic             last_of_item_o
);

  queue_ctrl_t q_ctrl;
  queue_stat_t q_stat;
  draw_rec_t   rec_in, rec_out;
  logic        q_push, q_pop;

  assign q_ctrl = '{push: q_push, pop: q_pop};

  iccp_front #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_in_i      (char_in_i),
    .end_of_string_i(end_of_string_i),
    .base_x_i       (base_x_i),
    .base_y_i       (base_y_i),
    .alpha_in_i     (alpha_in_i),
    .q_stat_i       (q_stat),
    .q_push_o       (q_push),
    .q_rec_o        (rec_in)
  );

  iccp_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(q_ctrl),
    .rec_i (rec_in),
    .rec_o (rec_out),
    .stat_o(q_stat)
  );

  iccp_back #(
    .FONT_PIXELS(FONT_PIXELS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_i         (rec_out),
    .q_stat_i      (q_stat),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .glyph_o       (glyph_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .alpha_out_o   (alpha_out_o),
    .italic_o      (italic_o),
    .is_shadow_o   (is_shadow_o),
    .last_of_item_o(last_of_item_o)
  );

endmodule

`default_nettype wire

FILE: src/iccp_checker.sv
// ----------------------------------------------------------------------------
// iccp_checker
// Port-level checks for the caret color code text parser.
// ----------------------------------------------------------------------------
`default_nettype none

module iccp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [12:0] pos_y_o,
  input wire logic [7:0]  glyph_o,
  input wire logic [7:0]  red_o,
  input wire logic [7:0]  green_o,
  input wire logic [7:0]  blue_o,
  input wire logic        is_shadow_o,
  input wire logic        last_of_item_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(glyph_o) && $stable(pos_y_o))
    else $error("stalled result changed");

  // a shadow draw is never marked last of its item
  a_shadow_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_shadow_o |-> !last_of_item_o)
    else $error("shadow draw marked last");

  a_shadow_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_shadow_o |-> red_o == 8'd0 && green_o == 8'd0 && blue_o == 8'd0)
    else $error("shadow draw not black");

  a_shadow_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_shadow_o |-> pos_y_o != 13'd0)
    else $error("shadow draw not offset in y");

endmodule

bind inline_color_code_text_parser_top iccp_checker u_iccp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .pos_y_o       (pos_y_o),
  .glyph_o       (glyph_o),
  .red_o         (red_o),
  .green_o       (green_o),
  .blue_o        (blue_o),
  .is_shadow_o   (is_shadow_o),
  .last_of_item_o(last_of_item_o)
);

`default_nettype wire
